// ===== design/suv_pkg.sv =====
// Shared types, constants and the arctangent table for the sphere UV mapper.
package suv_pkg;

  localparam int ANGLE_STEPS = 24;
  localparam int CORDIC_LAT  = ANGLE_STEPS + 5;
  localparam int ISQRT_STEPS = 32;

  // Angles are in units of 2^-32 turn, so pi is 2^31
  typedef logic signed [33:0] ang_t;
  typedef logic signed [33:0] vec_t;

  localparam ang_t PI_UNITS   = 34'sd2147483648;
  localparam ang_t HALF_PI    = 34'sd1073741824;

  typedef enum logic [1:0] {
    PHI_CORDIC,
    PHI_ZERO,
    PHI_PI,
    PHI_HALF
  } phi_sel_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        sphere_radius;
    logic [30:0]        zoom_factor;
  } in_item_t;

  typedef struct packed {
    logic [30:0] tex_u;
    logic [30:0] tex_v;
  } out_item_t;

  typedef struct packed {
    phi_sel_t    phi_sel;
    logic [30:0] zoom;
  } side_t;

  // atan(2^-i) in angle units, rounded to nearest
  function automatic ang_t atan_units(input int idx);
    ang_t a;
    case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      24: a = 34'sd41;
      25: a = 34'sd20;
      26: a = 34'sd10;
      27: a = 34'sd5;
      28: a = 34'sd3;
      29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/suv_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) with operand normalization.
module suv_cordic (
  input  logic          clk,
  input  logic          en,
  input  suv_pkg::vec_t x_i,
  input  suv_pkg::vec_t y_i,
  output suv_pkg::ang_t ang_o
);
  import suv_pkg::*;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic xz;
    logic yz;
  } flags_t;

  localparam int FL_LEN = CORDIC_LAT - 1;

  flags_t      fl_r [0:FL_LEN-1];
  logic [32:0] mxa_r, mya_r, mxb_r, myb_r;
  logic [5:0]  p_r;
  logic [5:0]  p_nxt;
  logic [30:0] sx_r, sy_r;
  logic [32:0] sx_nxt, sy_nxt;
  logic signed [35:0] cx_r [0:ANGLE_STEPS];
  logic signed [35:0] cy_r [0:ANGLE_STEPS];
  ang_t               cz_r [0:ANGLE_STEPS];
  ang_t               ang_r;
  logic        xneg_e, yneg_e;

  // Take magnitudes and note the special cases
  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= '{xneg: x_i[33], yneg: y_i[33], xz: (x_i == '0), yz: (y_i == '0)};
      mxa_r   <= x_i[33] ? 33'(-x_i) : x_i[32:0];
      mya_r   <= y_i[33] ? 33'(-y_i) : y_i[32:0];
      for (int i = 1; i < FL_LEN; i++) fl_r[i] <= fl_r[i-1];
    end
  end

  // Find the leading one of both magnitudes together
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 33; i++) begin
      if (mxa_r[i] | mya_r[i]) p_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      mxb_r <= mxa_r;
      myb_r <= mya_r;
    end
  end

  // Scale so the larger magnitude lands in [2^30, 2^31)
  always_comb begin
    if (p_r > 6'd30) begin
      sx_nxt = mxb_r >> (p_r - 6'd30);
      sy_nxt = myb_r >> (p_r - 6'd30);
    end else begin
      sx_nxt = mxb_r << (6'd30 - p_r);
      sy_nxt = myb_r << (6'd30 - p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= sx_nxt[30:0];
      sy_r <= sy_nxt[30:0];
    end
  end

  // Fold the left half plane onto the right one
  assign xneg_e = fl_r[2].xneg && (sx_r != '0);
  assign yneg_e = fl_r[2].yneg && (sy_r != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= 36'(sx_r);
      cy_r[0] <= (xneg_e ^ yneg_e) ? -36'(sy_r) : 36'(sy_r);
      if (xneg_e) cz_r[0] <= yneg_e ? -PI_UNITS : PI_UNITS;
      else        cz_r[0] <= '0;
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_r[k][35]) begin
          cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] + atan_units(k);
        end else begin
          cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] - atan_units(k);
        end
      end
    end
  end

  // Apply axis cases and clamp to [-pi, pi]
  always_ff @(posedge clk) begin
    if (en) begin
      if (fl_r[FL_LEN-1].yz) begin
        ang_r <= fl_r[FL_LEN-1].xneg ? PI_UNITS : '0;
      end else if (fl_r[FL_LEN-1].xz) begin
        ang_r <= fl_r[FL_LEN-1].yneg ? -HALF_PI : HALF_PI;
      end else if (cz_r[ANGLE_STEPS] > PI_UNITS) begin
        ang_r <= PI_UNITS;
      end else if (cz_r[ANGLE_STEPS] < -PI_UNITS) begin
        ang_r <= -PI_UNITS;
      end else begin
        ang_r <= cz_r[ANGLE_STEPS];
      end
    end
  end

  assign ang_o = ang_r;

endmodule

// ===== design/sphere_uv_mapper.sv =====
// Top level: spherical UV texture mapping pipeline.
//
//   channel | ports                        | payload
//   input   | in_valid, in_stall, in_data  | suv_pkg::in_item_t
//   output  | out_valid, out_stall, out_data | suv_pkg::out_item_t
//
// One item enters per cycle unless the pipeline is stalled; out_valid follows the input
// transfer through 69 register stages (13 + ISQRT_STEPS + ANGLE_STEPS), a depth set by
// the 32-stage square root followed by the polar CORDIC and the output multipliers.
// Reset clears only the valid bits. A stall on the output while out_valid is high
// freezes the whole pipeline at once, so nothing is lost or repeated; in_stall follows it.
module sphere_uv_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  suv_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output suv_pkg::out_item_t  out_data
);
  import suv_pkg::*;

  localparam int ST_H   = 6 + ISQRT_STEPS;
  localparam int ST_ANG = ST_H + CORDIC_LAT;
  localparam int LAST   = ST_ANG + 2;

  logic en;
  logic v_r [1:LAST];

  // stage 1
  logic               s1_cmd_r;
  logic signed [31:0] s1_px_r, s1_py_r, s1_pz_r;
  logic [30:0]        s1_rad_r, s1_zoom_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_dz_r;
  vec_t               th_x, th_y;
  ang_t               theta_c;

  // stages 2..6
  logic [32:0] s2_a_r, s2_b_r, s2_y_r, s3_a_r, s3_b_r, s3_y_r;
  logic        s2_ys_r, s3_ys_r, s4_ys_r, s5_ys_r;
  logic        s2_sub_r, s3_sub_r, s4_sub_r, s5_sub_r;
  side_t       side_nxt;
  side_t       sd_r [2:ST_ANG];
  logic [32:0] or_v;
  logic [5:0]  s3_p_r, p_nxt;
  logic [32:0] a_nxt, b_nxt, y_nxt;
  logic [30:0] s4_a_r, s4_b_r, s4_y_r, s5_y_r;
  logic [61:0] s5_sqa_r, s5_sqb_r, s5_sqy_r;
  logic signed [32:0] dx_m, dy_m, dz_m;

  // square root
  logic [63:0] sn_r [0:ISQRT_STEPS];
  logic [63:0] sr_r [0:ISQRT_STEPS];
  logic [30:0] qy_r [0:ISQRT_STEPS];
  logic        qs_r [0:ISQRT_STEPS];
  vec_t        po_x, po_y;
  ang_t        phi_c;

  ang_t        th_r [0:ST_H-2];

  // output math
  logic [32:0] t_val;
  logic [31:0] phi_val;
  logic [63:0] pu_r, pv_r;
  logic [64:0] u_sum, v_sum;
  logic [32:0] u_val, v_val;
  out_item_t   out_r;

  // Advance the whole pipeline unless a finished result is held
  assign en       = !v_r[LAST] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= LAST; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Stage 1: capture and form the center-to-point vector
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r  <= in_data.command;
      s1_px_r   <= in_data.point_x;
      s1_py_r   <= in_data.point_y;
      s1_pz_r   <= in_data.point_z;
      s1_rad_r  <= in_data.sphere_radius;
      s1_zoom_r <= in_data.zoom_factor;
      s1_dx_r   <= 33'(in_data.point_x) - 33'(in_data.centre_x);
      s1_dy_r   <= 33'(in_data.point_y) - 33'(in_data.centre_y);
      s1_dz_r   <= 33'(in_data.point_z) - 33'(in_data.centre_z);
    end
  end

  // Azimuth CORDIC runs straight from stage 1
  assign th_x = s1_cmd_r ? 34'(s1_dx_r) : 34'(s1_px_r);
  assign th_y = s1_cmd_r ? 34'(s1_dz_r) : 34'(s1_pz_r);

  suv_cordic u_theta (.clk(clk), .en(en), .x_i(th_x), .y_i(th_y), .ang_o(theta_c));

  // Stage 2: magnitudes for the polar path and its special cases
  assign dx_m = s1_dx_r[32] ? -s1_dx_r : s1_dx_r;
  assign dy_m = s1_dy_r[32] ? -s1_dy_r : s1_dy_r;
  assign dz_m = s1_dz_r[32] ? -s1_dz_r : s1_dz_r;

  always_comb begin
    side_nxt.zoom = s1_zoom_r;
    if (s1_cmd_r) begin
      if (s1_dx_r == '0 && s1_dy_r == '0 && s1_dz_r == '0) side_nxt.phi_sel = PHI_HALF;
      else                                                  side_nxt.phi_sel = PHI_CORDIC;
    end else if (33'(s1_py_r) >= $signed({2'b00, s1_rad_r})) begin
      side_nxt.phi_sel = PHI_ZERO;
    end else if (33'(s1_py_r) <= -$signed({2'b00, s1_rad_r})) begin
      side_nxt.phi_sel = PHI_PI;
    end else begin
      side_nxt.phi_sel = PHI_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r   <= s1_cmd_r ? dx_m : {2'b00, s1_rad_r};
      s2_b_r   <= s1_cmd_r ? dz_m : '0;
      s2_y_r   <= s1_cmd_r ? dy_m : (s1_py_r[31] ? 33'(-33'(s1_py_r)) : 33'(s1_py_r));
      s2_ys_r  <= s1_cmd_r ? s1_dy_r[32] : s1_py_r[31];
      s2_sub_r <= !s1_cmd_r;
      sd_r[2]  <= side_nxt;
      for (int i = 3; i <= ST_ANG; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // Stage 3: leading one of the three magnitudes
  assign or_v = s2_a_r | s2_b_r | s2_y_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 33; i++) begin
      if (or_v[i]) p_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p_r   <= p_nxt;
      s3_a_r   <= s2_a_r;
      s3_b_r   <= s2_b_r;
      s3_y_r   <= s2_y_r;
      s3_ys_r  <= s2_ys_r;
      s3_sub_r <= s2_sub_r;
    end
  end

  // Stage 4: common scale into [2^30, 2^31)
  always_comb begin
    if (s3_p_r > 6'd30) begin
      a_nxt = s3_a_r >> (s3_p_r - 6'd30);
      b_nxt = s3_b_r >> (s3_p_r - 6'd30);
      y_nxt = s3_y_r >> (s3_p_r - 6'd30);
    end else begin
      a_nxt = s3_a_r << (6'd30 - s3_p_r);
      b_nxt = s3_b_r << (6'd30 - s3_p_r);
      y_nxt = s3_y_r << (6'd30 - s3_p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a_r   <= a_nxt[30:0];
      s4_b_r   <= b_nxt[30:0];
      s4_y_r   <= y_nxt[30:0];
      s4_ys_r  <= s3_ys_r;
      s4_sub_r <= s3_sub_r;
    end
  end

  // Stage 5: squares
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sqa_r <= s4_a_r * s4_a_r;
      s5_sqb_r <= s4_b_r * s4_b_r;
      s5_sqy_r <= s4_y_r * s4_y_r;
      s5_y_r   <= s4_y_r;
      s5_ys_r  <= s4_ys_r;
      s5_sub_r <= s4_sub_r;
    end
  end

  // Stage 6: radicand for the horizontal part
  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= 64'(s5_sqa_r) + 64'(s5_sqb_r) - (s5_sub_r ? 64'(s5_sqy_r) : 64'd0);
      sr_r[0] <= '0;
      qy_r[0] <= s5_y_r;
      qs_r[0] <= s5_ys_r;
    end
  end

  // Floor square root, one result bit per stage
  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (sn_r[k] >= sr_r[k] + BIT) begin
          sn_r[k+1] <= sn_r[k] - (sr_r[k] + BIT);
          sr_r[k+1] <= (sr_r[k] >> 1) + BIT;
        end else begin
          sn_r[k+1] <= sn_r[k];
          sr_r[k+1] <= sr_r[k] >> 1;
        end
        qy_r[k+1] <= qy_r[k];
        qs_r[k+1] <= qs_r[k];
      end
    end
  end

  // Polar angle as atan2(h, y)
  assign po_x = qs_r[ISQRT_STEPS] ? -34'(qy_r[ISQRT_STEPS]) : 34'(qy_r[ISQRT_STEPS]);
  assign po_y = {2'b00, sr_r[ISQRT_STEPS][31:0]};

  suv_cordic u_phi (.clk(clk), .en(en), .x_i(po_x), .y_i(po_y), .ang_o(phi_c));

  // Hold the azimuth until the polar angle catches up
  always_ff @(posedge clk) begin
    if (en) begin
      th_r[0] <= theta_c;
      for (int i = 1; i <= ST_H - 2; i++) th_r[i] <= th_r[i-1];
    end
  end

  // Select the polar angle and scale both by the zoom
  always_comb begin
    t_val = 33'(th_r[ST_H-2] + PI_UNITS);
    case (sd_r[ST_ANG].phi_sel)
      PHI_CORDIC: phi_val = phi_c[33] ? 32'd0 : phi_c[31:0];
      PHI_ZERO:   phi_val = 32'd0;
      PHI_PI:     phi_val = PI_UNITS[31:0];
      PHI_HALF:   phi_val = HALF_PI[31:0];
      default:    phi_val = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r <= 64'(t_val) * 64'(sd_r[ST_ANG].zoom);
      pv_r <= 64'(phi_val) * 64'(sd_r[ST_ANG].zoom);
    end
  end

  // Round, shift and saturate
  assign u_sum = 65'(pu_r) + 65'h0_8000_0000;
  assign v_sum = 65'(pv_r) + 65'h0_4000_0000;
  assign u_val = u_sum[64:32];
  assign v_val = v_sum[63:31];

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.tex_u <= (u_val > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : u_val[30:0];
      out_r.tex_v <= (v_val > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : v_val[30:0];
    end
  end

  assign out_valid = v_r[LAST];
  assign out_data  = out_r;

endmodule
